[hw/rtl/ddw_pkg.sv]
// Shared types and constants for the decimal digit display writer.
// No dependencies; compile first.
`default_nettype none

package ddw_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned BCNT_W   = $clog2(VALUE_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_NUMBER  = 2'd0,
    MODE_DIGIT   = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_REFRESH = 2'd3
  } ddw_mode_e;

  typedef struct packed {
    ddw_mode_e             mode;
    logic [VALUE_W-1:0]    value;
    logic [POS_W-1:0]      position;
    logic [SYMBOL_W-1:0]   symbol;
  } ddw_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     digit_address;
    logic [SYMBOL_W-1:0]   digit_data;
    logic                  last;
  } ddw_out_t;

endpackage

`default_nettype wire

[hw/rtl/ddw_in_if.sv]
// Request channel: valid/ready handshake carrying one display update item.
// Depends on ddw_pkg.
`default_nettype none

interface ddw_in_if;
  import ddw_pkg::*;

  logic    valid;
  logic    ready;
  ddw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ddw_out_if.sv]
// Frame channel: valid/ready handshake carrying one register-write frame.
// Depends on ddw_pkg.
`default_nettype none

interface ddw_out_if;
  import ddw_pkg::*;

  logic     valid;
  logic     ready;
  ddw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/decimal_digit_display_writer.sv]
// Decimal digit display writer: shadow digit store plus frame generator.
// Depends on ddw_pkg, ddw_in_if, ddw_out_if.
//
// Usage:
//   in_i  carries update items (mode, value, position, symbol); one item is
//         worked on at a time and in_i.ready is high only when idle.
//   out_o carries register-write frames (digit_address = position + 1,
//         digit_data, last). Frames leave in ascending position order and
//         last marks the final frame of an item.
//   Number modes (write number, silent load): the item is accepted and
//         converted by shift-and-add-3, one step per value bit, then one
//         store write per digit follows. Digits above NUM_DIGITS are
//         dropped (value modulo 10^NUM_DIGITS).
//   Single digit: one frame. Positions at or above NUM_DIGITS are
//         dropped without a frame.
//   Refresh: each digit is read from the store (registered synchronous read)
//         and then sent as one frame.
//   In the number modes the conversion loop bounds throughput; the store has
//   one write port and one read port.
//   Stalls: one output register holds the pending frame; while the receiver
//         holds ready low the sequencer waits to send and nothing is lost.
//   Reset: async, active low. Control clears and per-digit valid bits drop,
//         so every digit reads as zero until written; no clearing pass.
`default_nettype none

module decimal_digit_display_writer #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ddw_in_if.sink     in_i,
  ddw_out_if.source  out_o
);
  import ddw_pkg::*;

  localparam int unsigned IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned BCD_W = 4 * NUM_DIGITS;
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_DIGITS - 1);
  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(VALUE_W - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;  // one value bit per cycle
  localparam logic [2:0] ST_STORE = 3'd2;  // write converted digits
  localparam logic [2:0] ST_SYM   = 3'd3;  // single symbol write
  localparam logic [2:0] ST_RD    = 3'd4;  // issue store read
  localparam logic [2:0] ST_EMIT  = 3'd5;  // send read data

  logic [2:0]          state_q, state_d;
  ddw_mode_e           mode_q, mode_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SYMBOL_W-1:0] sym_q, sym_d;

  // digit store: synchronous memory plus per-entry valid bits
  logic [SYMBOL_W-1:0] mem_q [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] vld_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [SYMBOL_W-1:0] mem_wdata;
  logic [SYMBOL_W-1:0] rd_data_q;
  logic                rd_vld_q;

  // output register
  logic     out_valid_q;
  ddw_out_t out_q, out_d;
  logic     out_load;
  logic     slot_free;

  logic [BCD_W-1:0] bcd_adj;
  logic             idx_last;
  logic             pos_ok;

  assign slot_free = !out_valid_q || out_o.ready;
  assign idx_last  = (idx_q == IDX_LAST);
  assign pos_ok    = ADDR_W'(in_i.data.position) < ADDR_W'(NUM_DIGITS);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // add-3 correction on every digit of 5 or more ahead of the shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    val_d     = val_q;
    bcd_d     = bcd_q;
    bcnt_d    = bcnt_q;
    idx_d     = idx_q;
    sym_d     = sym_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = sym_q;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mode_d = in_i.data.mode;
          val_d  = in_i.data.value;
          sym_d  = in_i.data.symbol;
          idx_d  = in_i.data.position[IDX_W-1:0];
          bcd_d  = '0;
          bcnt_d = '0;
          case (in_i.data.mode) inside
            MODE_NUMBER, MODE_LOAD: state_d = ST_CONV;
            MODE_DIGIT: state_d = pos_ok ? ST_SYM : ST_IDLE;
            default: begin
              idx_d   = '0;
              state_d = ST_RD;
            end
          endcase
        end
      end

      ST_CONV: begin
        bcd_d  = {bcd_adj[BCD_W-2:0], val_q[VALUE_W-1]};
        val_d  = {val_q[VALUE_W-2:0], 1'b0};
        bcnt_d = bcnt_q + BCNT_W'(1);
        if (bcnt_q == BCNT_LAST) begin
          idx_d   = '0;
          state_d = ST_STORE;
        end
      end

      ST_STORE: begin
        if (mode_q == MODE_LOAD || slot_free) begin
          mem_we    = 1'b1;
          mem_wdata = SYMBOL_W'(bcd_q[3:0]);
          bcd_d     = bcd_q >> 4;
          if (mode_q == MODE_NUMBER) begin
            out_load = 1'b1;
            out_d    = '{digit_address: ADDR_W'(idx_q) + ADDR_W'(1),
                         digit_data:    SYMBOL_W'(bcd_q[3:0]),
                         last:          idx_last};
          end
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_SYM: begin
        if (slot_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
          out_d    = '{digit_address: ADDR_W'(idx_q) + ADDR_W'(1),
                       digit_data:    sym_q,
                       last:          1'b1};
          state_d  = ST_IDLE;
        end
      end

      ST_RD: begin
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_d    = '{digit_address: ADDR_W'(idx_q) + ADDR_W'(1),
                       digit_data:    rd_vld_q ? rd_data_q : '0,
                       last:          idx_last};
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= vld_q[idx_q];
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    val_q  <= val_d;
    bcd_q  <= bcd_d;
    bcnt_q <= bcnt_d;
    idx_q  <= idx_d;
    sym_q  <= sym_d;
    out_q  <= out_d;
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[idx_q];
  end

endmodule

`default_nettype wire

[hw/rtl/ddw_checker.sv]
// Port-level checks for the decimal digit display writer, bound to the top.
// Depends on ddw_pkg and decimal_digit_display_writer.
`default_nettype none

module ddw_checker #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [ddw_pkg::ADDR_W-1:0]     out_addr_i,
  input wire logic [ddw_pkg::SYMBOL_W-1:0]   out_data_i,
  input wire logic                           out_last_i
);
  import ddw_pkg::*;

  // frame addresses stay inside the display
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_addr_i != '0 && out_addr_i <= ADDR_W'(NUM_DIGITS)))
    else $error("frame address out of range");

  // no new item taken while a burst still has frames to come
  a_no_accept_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> !in_ready_i)
    else $error("item accepted in the middle of a frame burst");

  // a stalled frame holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_addr_i) && $stable(out_data_i) && $stable(out_last_i)))
    else $error("stalled frame changed");

  // coming out of reset: idle and no frame pending
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (!out_valid_i && in_ready_i))
    else $error("block not idle after reset");

endmodule

bind decimal_digit_display_writer ddw_checker #(.NUM_DIGITS(NUM_DIGITS)) u_ddw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_addr_i  (out_o.data.digit_address),
  .out_data_i  (out_o.data.digit_data),
  .out_last_i  (out_o.data.last)
);

`default_nettype wire
